[design/itrd_pkg.sv]
// itrd_pkg: shared types, constants and the digit glyph function
// for the integer to radix digit converter; no dependencies
`default_nettype none

package itrd_pkg;

	localparam int BASE_W         = 6;
	localparam int CNT_W          = 7;
	localparam int DIGIT_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;
	localparam int BITS_PER_CYCLE = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [BASE_W-1:0] BASE_MIN    = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;
	localparam logic [BASE_W-1:0] BASE_RESET  = 6'd16;
	localparam logic [CNT_W-1:0]  COUNT_MIN   = 7'd1;
	localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd8;

	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h61;
	localparam logic [DIGIT_W-1:0] DECIMAL_TOP = 6'd10;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_RD,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [CNT_W-1:0]  count;
	} job_cfg_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_TOP) begin
			c = CHAR_ZERO + {1'b0, d};
		end else if (d < BASE_MAX) begin
			c = CHAR_A + {1'b0, d - DECIMAL_TOP};
		end else begin
			c = CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[design/itrd_if.sv]
// itrd_if: valid/ready channel interfaces for input values and output characters
// depends on itrd_pkg
`default_nettype none

interface itrd_value_if #(parameter int VALUE_WIDTH = 32) ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source(output valid, value, input ready);
	modport sink(input valid, value, output ready);
endinterface

interface itrd_char_if import itrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last;

	modport source(output valid, digit_char, last, input ready);
	modport sink(input valid, digit_char, last, output ready);
endinterface

`default_nettype wire

[design/itrd_front.sv]
// itrd_front: accepts values, tags each with the current base and digit count,
// and holds them in a two entry queue; depends on itrd_pkg, itrd_if
`default_nettype none

module itrd_front import itrd_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	itrd_value_if.sink                  din,
	input  wire job_cfg_t               cfg,
	output logic                        job_valid,
	input  wire logic                   job_ready,
	output logic [VALUE_WIDTH-1:0]      job_value,
	output job_cfg_t                    job_cfg
);

	logic [VALUE_WIDTH-1:0] value_q [QUEUE_DEPTH];
	job_cfg_t               cfg_q   [QUEUE_DEPTH];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;
	logic                   push;
	logic                   pop;

	assign din.ready = (cnt_q != 2'(QUEUE_DEPTH));
	assign push      = din.valid && din.ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job_value = value_q[rd_ptr_q];
	assign job_cfg   = cfg_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			value_q[wr_ptr_q] <= din.value;
			cfg_q[wr_ptr_q]   <= cfg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[design/itrd_back.sv]
// itrd_back: converts one queued value by repeated division by the base,
// eight quotient bits per cycle, then emits the stored digits as ascii
// depends on itrd_pkg, itrd_if
`default_nettype none

module itrd_back import itrd_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	output logic                        job_ready,
	input  wire logic [VALUE_WIDTH-1:0] job_value,
	input  wire job_cfg_t               job_cfg,
	itrd_char_if.source                 dout
);

	localparam int STEPS  = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
	localparam int DW     = STEPS * BITS_PER_CYCLE;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int AW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	back_state_t state_q, state_nx;

	logic [DW-1:0]      quo_q, quo_nx;
	logic [BASE_W-1:0]  rem_q, rem_nx;
	logic [BASE_W-1:0]  base_q, base_nx;
	logic [CNT_W-1:0]   count_q, count_nx;
	logic [CNT_W-1:0]   k_q, k_nx;
	logic [STEP_W-1:0]  step_q, step_nx;
	logic [CNT_W-1:0]   rd_idx_q, rd_idx_nx;
	logic [DIGIT_W-1:0] rd_data_q;
	logic               out_valid_q, out_valid_nx;
	logic [CHAR_W-1:0]  out_char_q, out_char_nx;
	logic               out_last_q, out_last_nx;

	logic [DIGIT_W-1:0] store [MAX_DIGITS];
	logic               st_we;
	logic [CNT_W-1:0]   st_pos;
	logic               rd_en;

	logic [DW-1:0]      div_quo;
	logic [BASE_W-1:0]  div_rem;
	logic [BASE_W:0]    r;
	logic [BITS_PER_CYCLE-1:0] qb;

	// one cycle of restoring division: eight dividend bits
	always_comb begin
		r  = {1'b0, rem_q};
		qb = '0;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			r = {r[BASE_W-1:0], quo_q[DW-1-i]};
			if (r >= {1'b0, base_q}) begin
				r = r - {1'b0, base_q};
				qb[BITS_PER_CYCLE-1-i] = 1'b1;
			end
		end
		div_rem = r[BASE_W-1:0];
		div_quo = (quo_q << BITS_PER_CYCLE) | DW'(qb);
	end

	assign st_pos = count_q - COUNT_MIN - k_q;

	always_comb begin
		state_nx     = state_q;
		quo_nx       = quo_q;
		rem_nx       = rem_q;
		base_nx      = base_q;
		count_nx     = count_q;
		k_nx         = k_q;
		step_nx      = step_q;
		rd_idx_nx    = rd_idx_q;
		out_valid_nx = out_valid_q && !dout.ready;
		out_char_nx  = out_char_q;
		out_last_nx  = out_last_q;
		job_ready    = 1'b0;
		st_we        = 1'b0;
		rd_en        = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					quo_nx   = DW'(job_value);
					rem_nx   = '0;
					base_nx  = job_cfg.base;
					count_nx = job_cfg.count;
					k_nx     = '0;
					step_nx  = '0;
					state_nx = B_DIV;
				end
			end
			B_DIV: begin
				quo_nx  = div_quo;
				rem_nx  = div_rem;
				step_nx = step_q + STEP_W'(1);
				if (step_q == STEP_W'(STEPS - 1)) begin
					st_we   = 1'b1;
					rem_nx  = '0;
					step_nx = '0;
					k_nx    = k_q + CNT_W'(1);
					if (k_q == count_q - COUNT_MIN) begin
						rd_idx_nx = '0;
						state_nx  = B_RD;
					end
				end
			end
			B_RD: begin
				rd_en    = 1'b1;
				state_nx = B_OUT;
			end
			B_OUT: begin
				if (!out_valid_q || dout.ready) begin
					out_valid_nx = 1'b1;
					out_char_nx  = glyph(rd_data_q);
					out_last_nx  = (rd_idx_q == count_q - COUNT_MIN);
					if (rd_idx_q == count_q - COUNT_MIN) begin
						state_nx = B_IDLE;
					end else begin
						rd_idx_nx = rd_idx_q + CNT_W'(1);
						state_nx  = B_RD;
					end
				end
			end
			default: begin
				state_nx = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_pos[AW-1:0]] <= div_rem;
		end
		if (rd_en) begin
			rd_data_q <= store[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		quo_q      <= quo_nx;
		rem_q      <= rem_nx;
		base_q     <= base_nx;
		count_q    <= count_nx;
		out_char_q <= out_char_nx;
		out_last_q <= out_last_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			k_q         <= '0;
			step_q      <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			k_q         <= k_nx;
			step_q      <= step_nx;
			rd_idx_q    <= rd_idx_nx;
			out_valid_q <= out_valid_nx;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.digit_char = out_char_q;
	assign dout.last       = out_last_q;

endmodule

`default_nettype wire

[design/int_to_radix_digits_top.sv]
// int_to_radix_digits_top: integer to base-n ascii converter with apb registers
// depends on itrd_pkg, itrd_if, itrd_front, itrd_back
//
// usage
//   din carries one unsigned value per transfer. for each value the block sends
//   exactly digit_count characters on dout, most significant first, with last
//   set on the final one. digits are 0-9 then a-z, leading positions are '0',
//   and digits above digit_count are dropped.
//   registers: base at byte 0 (writes of pwdata[5:0] saturate to 2..36, reset 16),
//   digit_count at byte 4 (writes of pwdata[5:0] saturate to 1..MAX_DIGITS, reset 8).
//   conversion: the shared divider retires eight quotient bits a cycle,
//   and the store is read ahead of each character.
//   a two entry queue takes values while a conversion runs; din.ready drops
//   when it is full.
//   a stalled dout holds its character; the converter waits and the queue
//   keeps filling.
//   reset empties the queue, drops any conversion in flight and restores
//   the register defaults.
`default_nettype none

module int_to_radix_digits_top import itrd_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	itrd_value_if.sink             din,
	itrd_char_if.source            dout,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic [BASE_W-1:0] base_q;
	logic [CNT_W-1:0]  count_q;
	logic              wr_en;
	logic [BASE_W-1:0] wbits;
	logic [BASE_W-1:0] base_sat;
	logic [CNT_W-1:0]  count_sat;

	job_cfg_t               cur_cfg;
	logic                   job_valid;
	logic                   job_ready;
	logic [VALUE_WIDTH-1:0] job_value;
	job_cfg_t               job_cfg;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wbits  = pwdata[BASE_W-1:0];

	always_comb begin
		if (wbits < BASE_MIN) begin
			base_sat = BASE_MIN;
		end else if (wbits > BASE_MAX) begin
			base_sat = BASE_MAX;
		end else begin
			base_sat = wbits;
		end
		if (wbits == '0) begin
			count_sat = COUNT_MIN;
		end else if ({1'b0, wbits} > CNT_W'(MAX_DIGITS)) begin
			count_sat = CNT_W'(MAX_DIGITS);
		end else begin
			count_sat = {1'b0, wbits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			count_q <= (COUNT_RESET > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : COUNT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_BASE:  base_q  <= base_sat;
				REG_COUNT: count_q <= count_sat;
				default:   ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_COUNT) ? DATA_W'(count_q) : DATA_W'(base_q);

	assign cur_cfg.base  = base_q;
	assign cur_cfg.count = count_q;

	itrd_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.cfg       (cur_cfg),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_value (job_value),
		.job_cfg   (job_cfg)
	);

	itrd_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_value (job_value),
		.job_cfg   (job_cfg),
		.dout      (dout)
	);

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.ready && dout.last |=> !dout.valid)
		else $error("character follows last without a new conversion");

	a_base_sat: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && paddr[2] == REG_BASE |=> base_q >= BASE_MIN && base_q <= BASE_MAX)
		else $error("base register out of range after write");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && paddr[2] == REG_COUNT |=>
		count_q >= COUNT_MIN && count_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count register out of range after write");

endmodule

`default_nettype wire
